// ===== src/column_keyed_write_buffer_unit_macros.svh =====
// Assertion macros shared by the column keyed write buffer RTL.
// Needs a clock named clk and an active low reset named rst_n in scope.
`ifndef COLUMN_KEYED_WRITE_BUFFER_UNIT_MACROS_SVH
`define COLUMN_KEYED_WRITE_BUFFER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CKWB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("column keyed write buffer assertion failed");
`define CKWB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("column keyed write buffer assertion failed");
`else
`define CKWB_ASSERT_NOW(label, ante, cons)
`define CKWB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/ckwb_pkg.sv =====
// Package for the column keyed write buffer: sizes, codes, item types.
// Used by the hasher, the top module and the testbench; depends on nothing.
package ckwb_pkg;
    localparam int CAPACITY     = 64;
    localparam int BUCKET_COUNT = 64;
    localparam int HEIGHT_LIMIT = 256;

    localparam int SLOT_W   = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int BUCKET_W = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int ENTRY_W  = 32 + 32 + 8 + 16;

    localparam logic [SLOT_W-1:0] NIL_SLOT = SLOT_W'(CAPACITY);
    localparam logic [30:0] REFUSE_MAX = 31'h7FFF_FFFF;

    localparam logic [31:0] HASH_MUL_X = 32'h9E37_79B1;
    localparam logic [31:0] HASH_MUL_Z = 32'h85EB_CA77;
    localparam int HASH_SHIFT   = 15;
    localparam int COLUMN_SHIFT = 4;

    localparam logic [1:0] ACT_RECORD = 2'd0;
    localparam logic [1:0] ACT_DRAIN  = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [2:0] ST_STORED  = 3'd0;
    localparam logic [2:0] ST_HEIGHT  = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_DRAINED = 3'd3;
    localparam logic [2:0] ST_NONE    = 3'd4;
    localparam logic [2:0] ST_CLEARED = 3'd5;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [15:0]        block_value;
        logic signed [27:0] column_x;
        logic signed [27:0] column_z;
    } req_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               last;
        logic signed [31:0] out_x;
        logic [7:0]         out_y;
        logic signed [31:0] out_z;
        logic [15:0]        out_value;
        logic [6:0]         pending_count;
        logic [30:0]        refusal_count;
        logic [6:0]         drained_total;
    } rsp_item_t;
endpackage

// ===== src/ckwb_ram.sv =====
// Generic single write port RAM with one registered read port.
// Depends on nothing.
module ckwb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/ckwb_hasher.sv =====
// Column hash built around one shared 32 by 32 multiplier, used first for the x product and then for the z product.
// Depends on ckwb_pkg.
module ckwb_hasher
    import ckwb_pkg::*;
(
    input  logic                clk,
    input  logic                first,
    input  logic [31:0]         col_x,
    input  logic [31:0]         col_z,
    output logic [BUCKET_W-1:0] bucket
);
    logic [31:0] product;
    logic [31:0] prod_x_reg;
    logic [31:0] mixed;
    logic [31:0] folded;

    assign product = first ? (col_x * HASH_MUL_X) : (col_z * HASH_MUL_Z);
    assign mixed   = prod_x_reg ^ product;
    assign folded  = mixed ^ (mixed >> HASH_SHIFT);
    assign bucket  = (BUCKET_COUNT > 1) ? folded[BUCKET_W-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (first)
        begin
            prod_x_reg <= product;
        end
    end
endmodule

// ===== src/column_keyed_write_buffer_unit.sv =====
// Column keyed write buffer: chained hash store of pending block writes.
// Depends on ckwb_pkg, ckwb_ram, ckwb_hasher and the assertion macro header.
//
// After an item is taken, a record hashes its column, reads the bucket head and walks the
// bucket chain, then updates the entry that holds its coordinate or, if none does, inserts
// a new entry or is refused when the store is full. A drain walks the chain of its
// column's bucket and unlinks and frees each entry of that column. A walk follows at most
// 64 entries, each step a registered read of the entry and link memories. A clear, a
// rejected height and an unknown action, which gives no result, finish in the cycle
// they are taken. A stalled result register holds the block back. The block takes one
// item at a time, and only when the result register is empty or is being read in that cycle.
`include "column_keyed_write_buffer_unit_macros.svh"
module column_keyed_write_buffer_unit
    import ckwb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_H1    = 4'd1;
    localparam logic [3:0] S_H2    = 4'd2;
    localparam logic [3:0] S_HEAD  = 4'd3;
    localparam logic [3:0] S_CMP   = 4'd4;
    localparam logic [3:0] S_ALLOC = 4'd5;
    localparam logic [3:0] S_INS   = 4'd6;
    localparam logic [3:0] S_UNL   = 4'd7;
    localparam logic [3:0] S_FRE   = 4'd8;
    localparam logic [3:0] S_END   = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       drain_reg, drain_next;
    logic [31:0] cx_reg, cx_next, cz_reg, cz_next;
    logic [31:0] x_reg, x_next, z_reg, z_next;
    logic [7:0]  y_reg, y_next;
    logic [15:0] val_reg, val_next;
    logic [BUCKET_W-1:0] bucket_reg, bucket_next;
    logic [SLOT_W-1:0] head_reg, head_next, cur_reg, cur_next, prev_reg, prev_next;
    logic [SLOT_W-1:0] link_reg, link_next, slot_reg, slot_next;
    logic              from_free_reg, from_free_next;
    logic [SLOT_W-1:0] free_reg, free_next, fresh_reg, fresh_next;
    logic [SLOT_W-1:0] held_reg, held_next, guard_reg, guard_next;
    logic [SLOT_W-1:0] count_reg, count_next;
    logic [30:0]       refused_reg, refused_next;
    logic [BUCKET_COUNT-1:0] bvalid_reg, bvalid_next;
    logic       pend_valid_reg, pend_valid_next;
    rsp_item_t  pend_reg, pend_next;
    logic       rsp_valid_reg;
    rsp_item_t  rsp_reg;

    logic       out_free, emit, accept, hash_first;
    rsp_item_t  emit_item;
    logic [BUCKET_W-1:0] hash_bucket;
    logic [IDX_W-1:0]    rd_idx, link_raddr;
    logic [ENTRY_W-1:0]  entry_rdata, entry_wdata;
    logic                entry_we;
    logic [IDX_W-1:0]    entry_waddr;
    logic [SLOT_W-1:0]   link_rdata, link_wdata, head_rdata, head_wdata;
    logic [IDX_W-1:0]    link_waddr;
    logic                link_we, head_we;
    logic [31:0] e_x, e_z;
    logic [7:0]  e_y;
    logic [15:0] e_val;
    logic        key_hit, col_hit, walk_end;
    logic [SLOT_W-1:0] guard_inc;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !(state_reg == S_IDLE && out_free);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign {e_x, e_z, e_y, e_val} = entry_rdata;
    assign key_hit   = (e_y == y_reg) && (e_x == x_reg) && (e_z == z_reg);
    assign col_hit   = (($signed(e_x) >>> COLUMN_SHIFT) == $signed(cx_reg))
                    && (($signed(e_z) >>> COLUMN_SHIFT) == $signed(cz_reg));
    assign guard_inc = guard_reg + SLOT_W'(1);
    assign walk_end  = (link_rdata == NIL_SLOT) || (guard_inc >= SLOT_W'(CAPACITY));

    ckwb_hasher u_hasher (
        .clk    (clk),
        .first  (hash_first),
        .col_x  (cx_reg),
        .col_z  (cz_reg),
        .bucket (hash_bucket)
    );

    ckwb_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_entry_ram (
        .clk   (clk),
        .we    (entry_we),
        .waddr (entry_waddr),
        .wdata (entry_wdata),
        .raddr (rd_idx),
        .rdata (entry_rdata)
    );

    ckwb_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    ckwb_ram #(.WIDTH(SLOT_W), .DEPTH(BUCKET_COUNT)) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (bucket_reg),
        .wdata (head_wdata),
        .raddr ((state_reg == S_H2) ? hash_bucket : bucket_reg),
        .rdata (head_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        drain_next      = drain_reg;
        cx_next         = cx_reg;
        cz_next         = cz_reg;
        x_next          = x_reg;
        z_next          = z_reg;
        y_next          = y_reg;
        val_next        = val_reg;
        bucket_next     = bucket_reg;
        head_next       = head_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        link_next       = link_reg;
        slot_next       = slot_reg;
        from_free_next  = from_free_reg;
        free_next       = free_reg;
        fresh_next      = fresh_reg;
        held_next       = held_reg;
        guard_next      = guard_reg;
        count_next      = count_reg;
        refused_next    = refused_reg;
        bvalid_next     = bvalid_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        emit            = 1'b0;
        emit_item       = '0;
        emit_item.last  = 1'b1;
        hash_first      = (state_reg == S_H1);
        rd_idx          = cur_reg[IDX_W-1:0];
        link_raddr      = cur_reg[IDX_W-1:0];
        entry_we        = 1'b0;
        entry_waddr     = slot_reg[IDX_W-1:0];
        entry_wdata     = {x_reg, z_reg, y_reg, val_reg};
        link_we         = 1'b0;
        link_waddr      = cur_reg[IDX_W-1:0];
        link_wdata      = link_reg;
        head_we         = 1'b0;
        head_wdata      = link_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    x_next     = req.coord_x;
                    z_next     = req.coord_z;
                    y_next     = req.coord_y[7:0];
                    val_next   = req.block_value;
                    guard_next = '0;
                    count_next = '0;
                    prev_next  = NIL_SLOT;
                    unique case (req.action)
                        ACT_RECORD:
                        begin
                            drain_next = 1'b0;
                            cx_next    = 32'($signed(req.coord_x) >>> COLUMN_SHIFT);
                            cz_next    = 32'($signed(req.coord_z) >>> COLUMN_SHIFT);
                            if (req.coord_y >= 32'(HEIGHT_LIMIT) || req.coord_y < 0)
                            begin
                                emit                    = 1'b1;
                                emit_item.status        = ST_HEIGHT;
                                emit_item.pending_count = 7'(held_reg);
                                emit_item.refusal_count = refused_reg;
                            end
                            else
                            begin
                                state_next = S_H1;
                            end
                        end
                        ACT_DRAIN:
                        begin
                            drain_next = 1'b1;
                            cx_next    = 32'(req.column_x);
                            cz_next    = 32'(req.column_z);
                            state_next = S_H1;
                        end
                        ACT_CLEAR:
                        begin
                            bvalid_next             = '0;
                            free_next               = NIL_SLOT;
                            fresh_next              = '0;
                            held_next               = '0;
                            refused_next            = '0;
                            emit                    = 1'b1;
                            emit_item.status        = ST_CLEARED;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_H1:
            begin
                state_next = S_H2;
            end
            S_H2:
            begin
                bucket_next = hash_bucket;
                state_next  = S_HEAD;
            end
            S_HEAD:
            begin
                head_next = bvalid_reg[bucket_reg] ? head_rdata : NIL_SLOT;
                cur_next  = head_next;
                rd_idx    = head_next[IDX_W-1:0];
                link_raddr = head_next[IDX_W-1:0];
                if (head_next == NIL_SLOT)
                begin
                    state_next = drain_reg ? S_END : S_ALLOC;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (!drain_reg)
                begin
                    if (key_hit)
                    begin
                        if (out_free)
                        begin
                            slot_next               = cur_reg;
                            entry_we                = 1'b1;
                            entry_waddr             = cur_reg[IDX_W-1:0];
                            emit                    = 1'b1;
                            emit_item.status        = ST_STORED;
                            emit_item.pending_count = 7'(held_reg);
                            emit_item.refusal_count = refused_reg;
                            state_next              = S_IDLE;
                        end
                    end
                    else
                    begin
                        guard_next = guard_inc;
                        if (walk_end)
                        begin
                            state_next = S_ALLOC;
                        end
                        else
                        begin
                            cur_next   = link_rdata;
                            rd_idx     = link_rdata[IDX_W-1:0];
                            link_raddr = link_rdata[IDX_W-1:0];
                        end
                    end
                end
                else
                begin
                    guard_next = guard_inc;
                    link_next  = link_rdata;
                    if (col_hit)
                    begin
                        state_next = S_UNL;
                    end
                    else
                    begin
                        prev_next = cur_reg;
                        if (walk_end)
                        begin
                            state_next = S_END;
                        end
                        else
                        begin
                            cur_next   = link_rdata;
                            rd_idx     = link_rdata[IDX_W-1:0];
                            link_raddr = link_rdata[IDX_W-1:0];
                        end
                    end
                end
            end
            S_ALLOC:
            begin
                link_raddr = free_reg[IDX_W-1:0];
                if (held_reg >= SLOT_W'(CAPACITY)
                    || (free_reg == NIL_SLOT && fresh_reg >= SLOT_W'(CAPACITY)))
                begin
                    if (out_free)
                    begin
                        if (refused_reg < REFUSE_MAX)
                        begin
                            refused_next = refused_reg + 31'd1;
                        end
                        emit                    = 1'b1;
                        emit_item.status        = ST_FULL;
                        emit_item.pending_count = 7'(held_reg);
                        emit_item.refusal_count = refused_next;
                        state_next              = S_IDLE;
                    end
                end
                else if (free_reg != NIL_SLOT)
                begin
                    slot_next      = free_reg;
                    from_free_next = 1'b1;
                    state_next     = S_INS;
                end
                else
                begin
                    slot_next      = fresh_reg;
                    fresh_next     = fresh_reg + SLOT_W'(1);
                    from_free_next = 1'b0;
                    state_next     = S_INS;
                end
            end
            S_INS:
            begin
                link_raddr = free_reg[IDX_W-1:0];
                if (out_free)
                begin
                    if (from_free_reg)
                    begin
                        free_next = link_rdata;
                    end
                    entry_we    = 1'b1;
                    link_we     = 1'b1;
                    link_waddr  = slot_reg[IDX_W-1:0];
                    link_wdata  = head_reg;
                    head_we     = 1'b1;
                    head_wdata  = slot_reg;
                    bvalid_next[bucket_reg] = 1'b1;
                    held_next   = held_reg + SLOT_W'(1);
                    emit                    = 1'b1;
                    emit_item.status        = ST_STORED;
                    emit_item.pending_count = 7'(held_next);
                    emit_item.refusal_count = refused_reg;
                    state_next  = S_IDLE;
                end
            end
            S_UNL:
            begin
                if (prev_reg == NIL_SLOT)
                begin
                    head_we    = 1'b1;
                    head_wdata = link_reg;
                    bvalid_next[bucket_reg] = 1'b1;
                end
                else
                begin
                    link_we    = 1'b1;
                    link_waddr = prev_reg[IDX_W-1:0];
                    link_wdata = link_reg;
                end
                state_next = S_FRE;
            end
            S_FRE:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        emit      = 1'b1;
                        emit_item = pend_reg;
                    end
                    link_we    = 1'b1;
                    link_wdata = free_reg;
                    free_next  = cur_reg;
                    if (held_reg != '0)
                    begin
                        held_next = held_reg - SLOT_W'(1);
                    end
                    count_next              = count_reg + SLOT_W'(1);
                    pend_valid_next         = 1'b1;
                    pend_next.status        = ST_DRAINED;
                    pend_next.last          = 1'b0;
                    pend_next.out_x         = e_x;
                    pend_next.out_y         = e_y;
                    pend_next.out_z         = e_z;
                    pend_next.out_value     = e_val;
                    pend_next.pending_count = 7'(held_next);
                    pend_next.refusal_count = refused_reg;
                    pend_next.drained_total = 7'(count_next);
                    if (link_reg == NIL_SLOT || guard_reg >= SLOT_W'(CAPACITY))
                    begin
                        state_next = S_END;
                    end
                    else
                    begin
                        cur_next   = link_reg;
                        rd_idx     = link_reg[IDX_W-1:0];
                        link_raddr = link_reg[IDX_W-1:0];
                        state_next = S_CMP;
                    end
                end
            end
            S_END:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (pend_valid_reg)
                    begin
                        emit_item      = pend_reg;
                        emit_item.last = 1'b1;
                    end
                    else
                    begin
                        emit_item.status        = ST_NONE;
                        emit_item.pending_count = 7'(held_reg);
                        emit_item.refusal_count = refused_reg;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            drain_reg      <= 1'b0;
            from_free_reg  <= 1'b0;
            free_reg       <= NIL_SLOT;
            fresh_reg      <= '0;
            held_reg       <= '0;
            refused_reg    <= '0;
            bvalid_reg     <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            drain_reg      <= drain_next;
            from_free_reg  <= from_free_next;
            free_reg       <= free_next;
            fresh_reg      <= fresh_next;
            held_reg       <= held_next;
            refused_reg    <= refused_next;
            bvalid_reg     <= bvalid_next;
            pend_valid_reg <= pend_valid_next;
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg     <= cx_next;
        cz_reg     <= cz_next;
        x_reg      <= x_next;
        z_reg      <= z_next;
        y_reg      <= y_next;
        val_reg    <= val_next;
        bucket_reg <= bucket_next;
        head_reg   <= head_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        link_reg   <= link_next;
        slot_reg   <= slot_next;
        guard_reg  <= guard_next;
        count_reg  <= count_next;
        pend_reg   <= pend_next;
        if (emit)
        begin
            rsp_reg <= emit_item;
        end
    end

    `CKWB_ASSERT_NOW(a_held_bounded, 1'b1, held_reg <= SLOT_W'(CAPACITY))
    `CKWB_ASSERT_NOW(a_fresh_bounded, 1'b1, fresh_reg <= SLOT_W'(CAPACITY))
    `CKWB_ASSERT_NOW(a_take_only_idle, !req_stall, state_reg == S_IDLE)
    `CKWB_ASSERT_NOW(a_no_pend_idle, state_reg == S_IDLE, !pend_valid_reg)
    `CKWB_ASSERT_NEXT(a_emit_shows, emit, rsp_valid)
endmodule

// ===== bench/tb_column_keyed_write_buffer_unit.sv =====
// Testbench for column_keyed_write_buffer_unit: random and directed records, drains, clears.
// Predicts every result with its own hash store model; depends on ckwb_pkg and the RTL.
module tb_column_keyed_write_buffer_unit;
    import ckwb_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_item_t rsp;

    column_keyed_write_buffer_unit dut (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    localparam logic [1:0] ACT_UNKNOWN = 2'd3;

    req_item_t pending_items[$];
    rsp_item_t expected_results[$];
    int        mismatch_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        stimulus_done;

    logic [6:0]  model_head[BUCKET_COUNT];
    logic [31:0] model_x[CAPACITY];
    logic [31:0] model_z[CAPACITY];
    logic [7:0]  model_y[CAPACITY];
    logic [15:0] model_value[CAPACITY];
    logic [6:0]  model_link[CAPACITY];
    logic [6:0]  model_free;
    logic [6:0]  model_fresh;
    logic [6:0]  model_held;
    logic [30:0] model_refused;

    always #5 clk = ~clk;

    function automatic logic [31:0] column_index(logic [31:0] v);
        return 32'($signed(v) >>> 4);
    endfunction

    function automatic logic [5:0] bucket_of(logic [31:0] cx, logic [31:0] cz);
        logic [31:0] h;
        h = (cx * 32'h9E37_79B1) ^ (cz * 32'h85EB_CA77);
        h = h ^ (h >> 15);
        return h[5:0];
    endfunction

    function automatic void clear_store();
        for (int i = 0; i < BUCKET_COUNT; i++) model_head[i] = 7'd64;
        model_free = 7'd64;
        model_fresh = 0;
        model_held = 0;
        model_refused = 0;
    endfunction

    function automatic rsp_item_t make_result(logic [2:0] st, logic [6:0] drained);
        rsp_item_t r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        r.pending_count = model_held;
        r.refusal_count = model_refused;
        r.drained_total = drained;
        return r;
    endfunction

    function automatic void predict_store(req_item_t it);
        logic [5:0]  b;
        logic [6:0]  i;
        logic [6:0]  slot;
        logic [6:0]  prev;
        logic [6:0]  nxt;
        logic [31:0] cx;
        logic [31:0] cz;
        int          n;
        rsp_item_t   r;
        if (it.action == ACT_RECORD) begin
            if ($unsigned(it.coord_y) >= HEIGHT_LIMIT) begin
                expected_results.push_back(make_result(ST_HEIGHT, 0));
                return;
            end
            b = bucket_of(column_index(it.coord_x), column_index(it.coord_z));
            i = model_head[b];
            while (i < 64) begin
                if (model_y[i] == it.coord_y[7:0] && model_x[i] == it.coord_x
                        && model_z[i] == it.coord_z) begin
                    model_value[i] = it.block_value;
                    expected_results.push_back(make_result(ST_STORED, 0));
                    return;
                end
                i = model_link[i];
            end
            slot = 7'd64;
            if (model_held < 64) begin
                if (model_free < 64) begin
                    slot = model_free;
                    model_free = model_link[slot];
                end else if (model_fresh < 64) begin
                    slot = model_fresh;
                    model_fresh++;
                end
            end
            if (slot >= 64) begin
                if (model_refused != REFUSE_MAX) model_refused++;
                expected_results.push_back(make_result(ST_FULL, 0));
                return;
            end
            model_x[slot] = it.coord_x;
            model_z[slot] = it.coord_z;
            model_y[slot] = it.coord_y[7:0];
            model_value[slot] = it.block_value;
            model_link[slot] = model_head[b];
            model_head[b] = slot;
            model_held++;
            expected_results.push_back(make_result(ST_STORED, 0));
        end else if (it.action == ACT_DRAIN) begin
            cx = 32'(it.column_x);
            cz = 32'(it.column_z);
            b = bucket_of(cx, cz);
            prev = 7'd64;
            i = model_head[b];
            n = 0;
            while (i < 64) begin
                nxt = model_link[i];
                if (column_index(model_x[i]) != cx || column_index(model_z[i]) != cz) begin
                    prev = i;
                end else begin
                    if (prev < 64) model_link[prev] = nxt;
                    else model_head[b] = nxt;
                    model_link[i] = model_free;
                    model_free = i;
                    if (model_held > 0) model_held--;
                    n++;
                    r = make_result(ST_DRAINED, 7'(n));
                    r.last = 1'b0;
                    r.out_x = model_x[i];
                    r.out_y = model_y[i];
                    r.out_z = model_z[i];
                    r.out_value = model_value[i];
                    expected_results.push_back(r);
                end
                i = nxt;
            end
            if (n == 0) expected_results.push_back(make_result(ST_NONE, 0));
            else expected_results[$].last = 1'b1;
        end else if (it.action == ACT_CLEAR) begin
            clear_store();
            expected_results.push_back(make_result(ST_CLEARED, 0));
        end
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch in %s: got %0h expected %0h", what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (req_valid && !req_stall) begin
                predict_store(req);
                void'(pending_items.pop_front());
            end
            if (!(req_valid && req_stall) && pending_items.size() > (req_valid && !req_stall)
                    && $urandom_range(99) >= send_idle_pct) begin
                req_valid <= 1'b1;
                req <= pending_items[(req_valid && !req_stall) ? 1 : 0];
            end else if (!(req_valid && req_stall)) begin
                req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        rsp_item_t want;
        if (rst_n) begin
            if (rsp_valid && !rsp_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result status", rsp.status, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (rsp.status != want.status)
                        report_mismatch("status", rsp.status, want.status);
                    if (rsp.last != want.last) report_mismatch("last", rsp.last, want.last);
                    if (rsp.out_x != want.out_x) report_mismatch("out_x", rsp.out_x, want.out_x);
                    if (rsp.out_y != want.out_y) report_mismatch("out_y", rsp.out_y, want.out_y);
                    if (rsp.out_z != want.out_z) report_mismatch("out_z", rsp.out_z, want.out_z);
                    if (rsp.out_value != want.out_value)
                        report_mismatch("out_value", rsp.out_value, want.out_value);
                    if (rsp.pending_count != want.pending_count)
                        report_mismatch("pending_count", rsp.pending_count, want.pending_count);
                    if (rsp.refusal_count != want.refusal_count)
                        report_mismatch("refusal_count", rsp.refusal_count, want.refusal_count);
                    if (rsp.drained_total != want.drained_total)
                        report_mismatch("drained_total", rsp.drained_total, want.drained_total);
                end
            end
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic req_item_t make_record(logic [31:0] x, logic [31:0] y,
                                              logic [31:0] z, logic [15:0] v);
        req_item_t it;
        it = '0;
        it.action = ACT_RECORD;
        it.coord_x = x;
        it.coord_y = y;
        it.coord_z = z;
        it.block_value = v;
        it.column_x = 28'($urandom);
        it.column_z = 28'($urandom);
        return it;
    endfunction

    function automatic req_item_t make_drain(logic [31:0] x, logic [31:0] z);
        req_item_t it;
        it = make_record($urandom, $urandom, $urandom, 16'($urandom));
        it.action = ACT_DRAIN;
        it.column_x = 28'(column_index(x));
        it.column_z = 28'(column_index(z));
        return it;
    endfunction

    function automatic req_item_t make_clear();
        req_item_t it;
        it = make_record($urandom, $urandom, $urandom, 16'($urandom));
        it.action = ACT_CLEAR;
        return it;
    endfunction

    initial begin
        int          k;
        logic [31:0] bx;
        logic [31:0] bz;
        req_item_t   it;
        clk = 0;
        rst_n = 0;
        req_valid = 0;
        req = '0;
        rsp_stall = 0;
        mismatch_count = 0;
        stimulus_done = 0;
        send_idle_pct = 28;
        recv_idle_pct = 64;
        clear_store();
        for (int i = 0; i < CAPACITY; i++) model_link[i] = 7'd64;

        pending_items.push_back(make_record(32'h7FFF_FFFF, 0, 32'h8000_0000, 16'hFFFF));
        pending_items.push_back(make_record(32'h8000_0000, 255, 32'h7FFF_FFFF, 0));
        pending_items.push_back(make_record(5, 256, 5, 1));
        pending_items.push_back(make_record(5, 32'hFFFF_FFFF, 5, 1));
        pending_items.push_back(make_record(32'h7FFF_FFFF, 0, 32'h8000_0000, 16'h1234));
        pending_items.push_back(make_record(32'h7FFF_FFF0, 9, 32'h8000_000F, 16'hAAAA));
        pending_items.push_back(make_drain(32'h7FFF_FFFF, 32'h8000_0000));
        pending_items.push_back(make_drain(32'h8000_0000, 32'h7FFF_FFFF));
        pending_items.push_back(make_drain(32'h100, 32'h100));
        it = make_clear();
        it.action = ACT_UNKNOWN;
        pending_items.push_back(it);
        pending_items.push_back(make_clear());
        for (int i = 0; i < 66; i++) pending_items.push_back(make_record(i, 1, 0, 16'(i)));
        pending_items.push_back(make_record(3, 1, 0, 16'hBEEF));
        pending_items.push_back(make_drain(0, 0));
        pending_items.push_back(make_drain(32'h40, 0));
        pending_items.push_back(make_clear());

        repeat (3) @(posedge clk);
        rst_n <= 1;

        k = 0;
        while (k < 170) begin
            if (k == 57) begin
                send_idle_pct = 64;
                recv_idle_pct = 28;
            end else if (k == 114) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            bx = $urandom_range(3) << 4;
            bz = $urandom_range(1) << 4;
            if ($urandom_range(9) == 0) begin
                bx = $urandom;
                bz = $urandom;
            end
            case ($urandom_range(19))
                0: pending_items.push_back(make_clear());
                1, 2, 3: pending_items.push_back(make_drain(bx, bz));
                4: pending_items.push_back(make_record(bx, $urandom, bz, 16'($urandom)));
                5:
                begin
                    it = make_clear();
                    it.action = ACT_UNKNOWN;
                    pending_items.push_back(it);
                    k--;
                end
                default: pending_items.push_back(make_record(bx + $urandom_range(15),
                    $urandom_range(3), bz + $urandom_range(15), 16'($urandom)));
            endcase
            k++;
            while (pending_items.size() > 20) @(posedge clk);
        end
        while (pending_items.size() > 0) @(posedge clk);
        while (expected_results.size() > 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("column_keyed_write_buffer_unit test passed");
        else
            $display("column_keyed_write_buffer_unit test failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("column_keyed_write_buffer_unit test failed");
        $finish;
    end
endmodule
